// ===== src/banked_stack_set_assert.svh =====
// Assertion macros used by the checker of the banked stack set.
`ifndef BANKED_STACK_SET_ASSERT_SVH
`define BANKED_STACK_SET_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define BSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bss_pkg.sv =====
// Package with the field widths, codes and defaults of the banked stack set.
`default_nettype none

package bss_pkg;

  // Field widths of the command and result words.
  localparam int OP_W   = 2;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;
  localparam int STAT_W = 2;

  // Default geometry.
  localparam int SUBSTACKS_DEF      = 8;
  localparam int SUBSTACK_DEPTH_DEF = 128;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_AT = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

// ===== src/bss_ifs.sv =====
// Command and result channel interfaces of the banked stack set.
`default_nettype none

interface bss_cmd_if import bss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] value;
  logic [IDX_W-1:0]         substack_index;

  modport source (output valid, output operation, output value, output substack_index,
                  input ready);
  modport sink (input valid, input operation, input value, input substack_index,
                output ready);
endinterface

interface bss_res_if import bss_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic                     is_empty;
  logic                     is_full;
  logic [IDX_W-1:0]         current_substack;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output top_value, output is_empty, output is_full,
                  output current_substack, output status, input ready);
  modport sink (input valid, input top_value, input is_empty, input is_full,
                input current_substack, input status, output ready);
endinterface

`default_nettype wire

// ===== src/banked_stack_set.sv =====
// Banked stack set: one logical stack split into SUBSTACKS substacks of SUBSTACK_DEPTH words.
// The cmd channel takes one word per operation: push, pop from the overall top, or pop from
// a named substack. The res channel returns exactly one word per command, with the top value
// of the highest non-empty substack, the empty and full flags, the current substack and a
// status (overflow and underflow leave the state untouched).
// An accepted command passes through the states S_MOD, S_TCNT and S_TELEM to S_RES, which
// loads the result word into the output register. One command is in work at a time; cmd.ready
// returns together with the result and the next word is taken at the following edge, even while
// the previous result still sits in the output register. The steps follow from the single read
// port of the count memory and the element memory: one read-modify-write of the touched count,
// then a count read and an element read for the top.
// Reset clears the pointer, the non-empty and full flags and the output valid flag at once; the
// element memory is not cleared, and counts read through the non-empty flags, so no clearing
// pass is needed. When the receiver stalls, the result word holds and the block waits in its
// last step until the word is taken.
`default_nettype none

module banked_stack_set import bss_pkg::*; #(
  parameter int SUBSTACKS      = SUBSTACKS_DEF,
  parameter int SUBSTACK_DEPTH = SUBSTACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bss_cmd_if.sink    cmd,
  bss_res_if.source  res
);

  localparam int SW    = (SUBSTACKS > 1) ? $clog2(SUBSTACKS) : 1;
  localparam int CW    = $clog2(SUBSTACK_DEPTH + 1);
  localparam int AW    = $clog2(SUBSTACKS * SUBSTACK_DEPTH);
  localparam int WORDS = SUBSTACKS * SUBSTACK_DEPTH;

  localparam logic [SW-1:0] LAST    = SW'(SUBSTACKS - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(SUBSTACK_DEPTH);
  localparam logic [AW-1:0] DEPTH_A = AW'(SUBSTACK_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_TCNT  = 3'd2;
  localparam logic [2:0] S_TELEM = 3'd3;
  localparam logic [2:0] S_RES   = 3'd4;

  // Index of the highest set bit, zero when none is set.
  function automatic logic [SW-1:0] highest(input logic [SUBSTACKS-1:0] v);
    logic [SW-1:0] r;
    r = '0;
    for (int i = 0; i < SUBSTACKS; i++) begin
      if (v[i]) r = SW'(i);
    end
    return r;
  endfunction

  // Control state.
  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [SW-1:0]        ptr;
  logic [SUBSTACKS-1:0] nonempty;
  logic [SUBSTACKS-1:0] full;

  // Command registers.
  logic [OP_W-1:0]     op_q;
  logic [DATA_W-1:0]   val_q;
  logic [STAT_W-1:0]   stat_q;
  logic [SW-1:0]       tgt_q;
  logic [SW-1:0]       walk_q;
  logic                hit_q;
  logic [SW-1:0]       h_q;
  logic                any_q;

  // Memories and their registered read data.
  logic [CW-1:0]     cnt_mem [SUBSTACKS];
  logic [DATA_W-1:0] elem_mem [WORDS];
  logic [CW-1:0]     cnt_rd;
  logic [DATA_W-1:0] elem_rd;

  // Output register.
  logic                     res_valid;
  logic signed [DATA_W-1:0] res_top;
  logic                     res_empty;
  logic                     res_full;
  logic [IDX_W-1:0]         res_cur;
  logic [STAT_W-1:0]        res_stat;

  // Decode of the incoming word.
  logic                 accept;
  logic [SUBSTACKS-1:0] le_mask;
  logic [SW-1:0]        walk;
  logic                 idx_ok;
  logic [SW-1:0]        idx_s;
  logic [SW-1:0]        tgt;
  logic [STAT_W-1:0]    stat;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign idx_ok    = int'(cmd.substack_index) < SUBSTACKS;
  assign idx_s     = SW'(cmd.substack_index);

  // Walking down stops at the highest non-empty substack at or below the pointer.
  always_comb begin
    for (int i = 0; i < SUBSTACKS; i++) begin
      le_mask[i] = (SW'(i) <= ptr);
    end
  end
  assign walk = highest(nonempty & le_mask);

  // Pick the substack whose count is touched, and decide the status up front.
  always_comb begin
    tgt  = ptr;
    stat = STAT_OK;
    case (cmd.operation)
      OP_PUSH: begin
        if (full[ptr]) begin
          if (ptr == LAST) stat = STAT_OVERFLOW;
          else tgt = ptr + 1'b1;
        end
      end
      OP_POP: begin
        tgt = walk;
        if (nonempty == '0) stat = STAT_UNDERFLOW;
      end
      OP_POP_AT: begin
        tgt = idx_ok ? idx_s : walk;
        if (!idx_ok || !nonempty[idx_s]) stat = STAT_UNDERFLOW;
      end
      default: begin
        tgt  = ptr;
        stat = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= cmd.operation;
      val_q  <= cmd.value;
      stat_q <= stat;
      tgt_q  <= tgt;
      walk_q <= walk;
      hit_q  <= nonempty[tgt];
    end
  end

  // Read-modify-write of the touched count.
  logic          do_push;
  logic          do_pop;
  logic [CW-1:0] cnt_eff;
  logic [CW-1:0] cnt_wdata;
  logic          mod_we;

  assign cnt_eff   = hit_q ? cnt_rd : '0;
  assign do_push   = (stat_q == STAT_OK) && (op_q == OP_PUSH);
  assign do_pop    = (stat_q == STAT_OK) && ((op_q == OP_POP) || (op_q == OP_POP_AT));
  assign cnt_wdata = do_push ? CW'(cnt_eff + 1'b1) : CW'(cnt_eff - 1'b1);
  assign mod_we    = (state == S_MOD) && (do_push || do_pop);

  // Highest non-empty substack after the update.
  logic [SW-1:0] h;
  assign h = highest(nonempty);

  // Count memory: one write and one read address per cycle.
  logic          cnt_re;
  logic [SW-1:0] cnt_raddr;
  assign cnt_re    = accept || (state == S_TCNT);
  assign cnt_raddr = (state == S_TCNT) ? h : tgt;

  always_ff @(posedge clk) begin
    if (mod_we) cnt_mem[tgt_q] <= cnt_wdata;
    if (cnt_re) cnt_rd <= cnt_mem[cnt_raddr];
  end

  // Element memory: pushes write, the top lookup reads.
  logic [AW-1:0] elem_waddr;
  logic [AW-1:0] elem_raddr;
  assign elem_waddr = AW'(tgt_q) * DEPTH_A + AW'(cnt_eff);
  assign elem_raddr = AW'(h_q) * DEPTH_A + AW'(cnt_rd) - 1'b1;

  always_ff @(posedge clk) begin
    if (state == S_MOD && do_push) elem_mem[elem_waddr] <= val_q;
    if (state == S_TELEM) elem_rd <= elem_mem[elem_raddr];
  end

  // Flags and pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      nonempty <= '0;
      full     <= '0;
    end else if (mod_we) begin
      nonempty[tgt_q] <= do_push ? 1'b1 : (cnt_eff != CW'(1));
      full[tgt_q]     <= do_push ? (cnt_wdata == DEPTH_C) : 1'b0;
      ptr             <= do_push ? tgt_q : walk_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_TCNT) begin
      h_q   <= h;
      any_q <= (nonempty != '0);
    end
  end

  // Sequencer.
  logic res_load;
  assign res_load = (state == S_RES) && (!res_valid || res.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_MOD;
      S_MOD:   state_next = S_TCNT;
      S_TCNT:  state_next = S_TELEM;
      S_TELEM: state_next = S_RES;
      S_RES:   if (res_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_top   <= any_q ? elem_rd : '0;
      res_empty <= !any_q;
      res_full  <= (ptr == LAST) && full[ptr];
      res_cur   <= IDX_W'(ptr);
      res_stat  <= stat_q;
    end
  end

  assign res.valid            = res_valid;
  assign res.top_value        = res_top;
  assign res.is_empty         = res_empty;
  assign res.is_full          = res_full;
  assign res.current_substack = res_cur;
  assign res.status           = res_stat;

endmodule

`default_nettype wire

// ===== src/bss_checker.sv =====
// Port-level checker of the banked stack set and its bind.
`default_nettype none

`include "banked_stack_set_assert.svh"

module bss_checker import bss_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cmd_valid,
  input logic                     cmd_ready,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic signed [DATA_W-1:0] top_value,
  input logic                     is_empty,
  input logic                     is_full,
  input logic [STAT_W-1:0]        status
);

  // An empty set reports a zero top value.
  `BSS_ASSERT_IMP(a_empty_top, clk, rst, res_valid && is_empty, top_value == '0, "empty set with nonzero top")

  // A refused push can only happen when the set is full.
  `BSS_ASSERT_IMP(a_ovf_full, clk, rst, res_valid && status == STAT_OVERFLOW, is_full, "overflow while not full")

  // One command at a time: the block is busy right after it takes a word.
  `BSS_ASSERT_NXT(a_busy, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "command taken while busy")

  // A stalled result word holds.
  `BSS_ASSERT_NXT(a_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(top_value) && $stable(status), "stalled result changed")

endmodule

bind banked_stack_set bss_checker u_bss_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .top_value (res.top_value),
  .is_empty  (res.is_empty),
  .is_full   (res.is_full),
  .status    (res.status)
);

`default_nettype wire
